>>> hdl/assert_macros.svh
// Assertion helpers clocked on clk, quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

>>> hdl/lrt_pkg.sv
package lrt_pkg;

  localparam int NP = 16;
  localparam int IW = $clog2(NP);
  localparam int CW = IW + 1;
  localparam int TW = 16;
  localparam logic [TW-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]    operation;
    logic [3:0]    slot;
    logic [7:0]    process_id;
    logic [TW-1:0] arrival_time;
    logic [TW-1:0] burst_time;
  } in_t;

  typedef struct packed {
    logic [TW-1:0] time_now;
    logic          idle;
    logic [7:0]    run_id;
    logic          first_run;
    logic [TW-1:0] response_time;
    logic          done_res;
    logic [TW-1:0] completion_time;
  } out_t;

  typedef struct packed {
    logic [7:0]    id;
    logic [TW-1:0] arrival;
    logic [TW-1:0] remaining;
    logic          started;
  } entry_t;

endpackage

>>> hdl/longest_remaining_time_scheduler.sv
// A load, clear or unused operation goes straight to the finish state to load its result.
// A tick scans the table with one table read per slot, then fetches and updates the chosen slot;
// if no slot is eligible, the tick only advances the time and skips the fetch and update.
// One item at a time: the next transfer is taken the cycle after the result is loaded into
// the output register, and the result waits in the finish state while the output stalls.
// Reset: rst is synchronous, active high; empties the table through per-slot valid bits.
module longest_remaining_time_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  lrt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lrt_pkg::out_t out_data
);
  import lrt_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t          state;
  entry_t          mem [NP];
  logic [NP-1:0]   ent_vld;
  entry_t          rd_q;
  logic            rd_vq;
  entry_t          ent;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;

  logic            preemptive;
  logic [TW-1:0]   cur_time;
  logic [TW-1:0]   time_adv;
  logic            cur_valid;
  logic [IW-1:0]   cur_slot;
  logic [IW-1:0]   run_slot;
  logic [CW-1:0]   cnt;
  logic            scan_pend;
  logic [IW-1:0]   scan_idx;
  logic            found;
  logic [IW-1:0]   best_idx;
  logic [TW-1:0]   best_rem;
  logic [TW-1:0]   best_arr;
  logic [IW-1:0]   sel_slot;
  logic            elig;
  logic            better;
  logic            accept;
  logic            slot_ok;
  logic            out_load;
  logic            done_now;
  out_t            res;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = (int'(in_data.slot) < NP);
  assign ent      = rd_vq ? rd_q : '0;
  assign elig     = (ent.remaining != '0) && (ent.arrival <= cur_time);
  assign better   = !found || (ent.remaining > best_rem) ||
                    ((ent.remaining == best_rem) && (ent.arrival < best_arr));
  assign sel_slot = (preemptive || !cur_valid) ? best_idx : cur_slot;
  assign time_adv = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign done_now = (ent.remaining == TW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = IW'(in_data.slot);
    wr_data = '{id: in_data.process_id, arrival: in_data.arrival_time,
                remaining: in_data.burst_time, started: 1'b0};
    unique case (state)
      ST_IDLE: begin
        wr_en = accept && (op_t'(in_data.operation) == OP_LOAD) && slot_ok;
      end
      ST_SCAN: begin
        rd_en = (cnt < CW'(NP));
      end
      ST_FETCH: begin
        rd_en   = found;
        rd_addr = sel_slot;
      end
      ST_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = run_slot;
        wr_data = '{id: ent.id, arrival: ent.arrival,
                    remaining: ent.remaining - 1'b1, started: 1'b1};
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ent_vld    <= '0;
      rd_vq      <= 1'b0;
      preemptive <= 1'b0;
      cur_time   <= '0;
      cur_valid  <= 1'b0;
      cur_slot   <= '0;
      cnt        <= '0;
      scan_pend  <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        preemptive <= cfg_data;
      end
      if (rd_en) begin
        rd_vq <= ent_vld[rd_addr];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res <= '{time_now: cur_time, idle: 1'b0, run_id: '0, first_run: 1'b0,
                     response_time: '0, done_res: 1'b0, completion_time: '0};
            unique case (op_t'(in_data.operation))
              OP_LOAD: begin
                state <= ST_FINISH;
                if (slot_ok) begin
                  ent_vld[IW'(in_data.slot)] <= 1'b1;
                  if (cur_valid && (cur_slot == IW'(in_data.slot))) begin
                    cur_valid <= 1'b0;
                  end
                end
              end
              OP_TICK: begin
                cnt       <= '0;
                scan_pend <= 1'b0;
                found     <= 1'b0;
                state     <= ST_SCAN;
              end
              OP_CLEAR: begin
                ent_vld   <= '0;
                cur_valid <= 1'b0;
                cur_slot  <= '0;
                cur_time  <= '0;
                state     <= ST_FINISH;
              end
              OP_UNUSED: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (cnt < CW'(NP)) begin
            cnt <= cnt + 1'b1;
          end
          scan_pend <= (cnt < CW'(NP));
          scan_idx  <= cnt[IW-1:0];
          if (scan_pend && elig && better) begin
            found    <= 1'b1;
            best_idx <= scan_idx;
            best_rem <= ent.remaining;
            best_arr <= ent.arrival;
          end
          if (cnt == CW'(NP)) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (!found) begin
            res.idle <= 1'b1;
            cur_time <= time_adv;
            state    <= ST_FINISH;
          end else begin
            cur_slot  <= sel_slot;
            cur_valid <= 1'b1;
            run_slot  <= sel_slot;
            state     <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res <= '{time_now: res.time_now, idle: 1'b0, run_id: ent.id,
                   first_run: !ent.started,
                   response_time: ent.started ? '0 : (cur_time - ent.arrival),
                   done_res: done_now,
                   completion_time: done_now ? time_adv : '0};
          if (done_now) begin
            cur_valid <= 1'b0;
          end
          ent_vld[run_slot] <= 1'b1;
          cur_time          <= time_adv;
          state             <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  `ASSERT_CLK(a_cur_slot_loaded, !cur_valid || ent_vld[cur_slot], "running slot not loaded")
  `ASSERT_NEXT(a_update_then_finish, state == ST_UPDATE, state == ST_FINISH, "update skipped finish")
  `ASSERT_CLK(a_scan_bound, cnt <= CW'(NP), "scan counter overran")
  `ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_data), "result lost")

endmodule

>>> tb/longest_remaining_time_scheduler_test.sv
`timescale 1ns / 100ps

module longest_remaining_time_scheduler_test;
  import lrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int SETTLE_CYCLES = 2 * (NP + 4);

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  logic [7:0] job_id [NP];
  logic [TW-1:0] job_arrival [NP];
  logic [TW-1:0] job_left [NP];
  logic job_started [NP];
  logic job_running;
  logic [IW-1:0] running_slot;
  logic [TW-1:0] clock_now;
  logic preempt_on;

  out_t pending_reports[$];
  int fail_count = 0;
  int sender_idle_pct = 25;
  int receiver_idle_pct = 85;
  int holdoff_left = 0;
  int unsigned cycle_count = 0;

  longest_remaining_time_scheduler uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task clear_schedule();
    for (int i = 0; i < NP; i++) begin
      job_id[i] = '0;
      job_arrival[i] = '0;
      job_left[i] = '0;
      job_started[i] = 1'b0;
    end
    job_running = 1'b0;
    running_slot = '0;
    clock_now = '0;
  endtask

  task predict_report(input in_t item);
    out_t rep;
    logic found;
    logic [IW-1:0] best;
    logic [IW-1:0] s;
    rep = '0;
    rep.time_now = clock_now;
    found = 1'b0;
    best = '0;
    case (op_t'(item.operation))
      OP_LOAD: begin
        s = item.slot;
        job_id[s] = item.process_id;
        job_arrival[s] = item.arrival_time;
        job_left[s] = item.burst_time;
        job_started[s] = 1'b0;
        if (job_running && running_slot == s) job_running = 1'b0;
      end
      OP_CLEAR: clear_schedule();
      OP_TICK: begin
        for (int i = 0; i < NP; i++) begin
          if (job_left[i] != 0 && job_arrival[i] <= clock_now) begin
            if (!found || job_left[i] > job_left[best] ||
                (job_left[i] == job_left[best] && job_arrival[i] < job_arrival[best])) begin
              best = i[IW-1:0];
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          rep.idle = 1'b1;
        end else begin
          if (preempt_on || !job_running) begin
            running_slot = best;
            job_running = 1'b1;
          end
          s = running_slot;
          rep.run_id = job_id[s];
          if (!job_started[s]) begin
            job_started[s] = 1'b1;
            rep.first_run = 1'b1;
            rep.response_time = clock_now - job_arrival[s];
          end
          job_left[s] = job_left[s] - 1'b1;
          if (job_left[s] == 0) begin
            rep.done_res = 1'b1;
            rep.completion_time = (clock_now == TIME_MAX) ? TIME_MAX : clock_now + 1'b1;
            job_running = 1'b0;
          end
        end
        if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
      end
      default: ;
    endcase
    pending_reports = {pending_reports, rep};
  endtask

  function automatic in_t make_item(input op_t op, input logic [3:0] slot,
                                    input logic [7:0] pid, input logic [TW-1:0] arrival,
                                    input logic [TW-1:0] burst);
    in_t item;
    item.operation = op;
    item.slot = slot;
    item.process_id = pid;
    item.arrival_time = arrival;
    item.burst_time = burst;
    return item;
  endfunction

  task send_item(input in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_report(item);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task load_job(input int slot, input int pid, input int arrival, input int burst);
    send_item(make_item(OP_LOAD, 4'(slot), 8'(pid), TW'(arrival), TW'(burst)));
  endtask

  task tick();
    send_item(make_item(OP_TICK, '0, '0, '0, '0));
  endtask

  task clear_all();
    send_item(make_item(OP_CLEAR, '0, '0, '0, '0));
  endtask

  task wait_idle();
    wait (pending_reports.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task set_preemptive(input logic on);
    wait_idle();
    cfg_write = 1'b1;
    cfg_data = on;
    @(negedge clk);
    cfg_write = 1'b0;
    preempt_on = on;
  endtask

  task compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_stall = (holdoff_left > 0) || ($urandom_range(99) < receiver_idle_pct);
    if (holdoff_left > 0) holdoff_left--;
  end

  always @(posedge clk) begin : check_results
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected transfer: time_now %0d", out_data.time_now);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("time_now", 32'(want.time_now), 32'(out_data.time_now));
        compare_field("idle", 32'(want.idle), 32'(out_data.idle));
        compare_field("run_id", 32'(want.run_id), 32'(out_data.run_id));
        compare_field("first_run", 32'(want.first_run), 32'(out_data.first_run));
        compare_field("response_time", 32'(want.response_time),
                      32'(out_data.response_time));
        compare_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
        compare_field("completion_time", 32'(want.completion_time),
                      32'(out_data.completion_time));
      end
    end
  end

  task test_empty_table();
    tick();
    send_item(make_item(OP_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF));
    load_job(3, 8'h11, 0, 0);
    tick();
  endtask

  task test_run_to_completion();
    load_job(15, 8'hFF, 0, 2);
    load_job(0, 8'h00, 16'hFFFF, 16'hFFFF);
    load_job(4, 8'h5A, 3, 5);
    tick();
    tick();
    tick();
    // overwrite slot 4, whose job has not yet run
    load_job(4, 8'h66, 0, 3);
    tick();
    tick();
    clear_all();
  endtask

  task test_preemption_ties();
    set_preemptive(1'b1);
    load_job(7, 8'h07, 0, 3);
    load_job(2, 8'h02, 0, 3);
    load_job(12, 8'h0C, 1, 4);
    repeat (6) tick();
    clear_all();
    tick();
  endtask

  task test_backpressure();
    holdoff_left = 300;
    load_job(1, 8'h21, 0, 4);
    load_job(9, 8'h29, 2, 6);
    load_job(5, 8'h25, 1, 6);
    repeat (13) tick();
    wait_idle();
  endtask

  task run_random_jobs(input int count);
    int sent;
    int jobs;
    int work;
    int ticks;
    in_t item;
    logic [63:0] r;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(4) != 0) begin
        clear_all();
        sent++;
      end
      jobs = $urandom_range(1, 6);
      work = 0;
      for (int k = 0; k < jobs; k++) begin
        item = make_item(OP_LOAD, 4'($urandom_range(NP - 1)), 8'($urandom_range(255)),
                         TW'(clock_now + $urandom_range(8)), TW'($urandom_range(1, 9)));
        case ($urandom_range(19))
          0: item.burst_time = '0;
          1: item.burst_time = TW'($urandom);
          2: item.arrival_time = TW'($urandom);
          default: ;
        endcase
        send_item(item);
        sent++;
        work += (item.burst_time > 16'd12) ? 12 : int'(item.burst_time);
      end
      ticks = work + $urandom_range(1, 4);
      if (ticks > 40) ticks = 40;
      for (int k = 0; k < ticks; k++) begin
        if ($urandom_range(14) == 0) begin
          r = {$urandom, $urandom};
          send_item(r[$bits(in_t)-1:0]);
        end else begin
          tick();
        end
        sent++;
      end
    end
  endtask

  task test_long_burst();
    clear_all();
    load_job(0, 8'hA5, 0, 16'hFFFF);
    load_job(1, 8'h3C, 16'hFFFF, 3);
    repeat (30) tick();
  endtask

  initial begin
    clear_schedule();
    preempt_on = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_run_to_completion();
    test_preemption_ties();
    set_preemptive(1'b0);
    run_random_jobs(180);
    set_preemptive(1'b1);
    run_random_jobs(180);

    sender_idle_pct = 85;
    receiver_idle_pct = 25;
    test_backpressure();
    run_random_jobs(180);
    set_preemptive(1'b0);
    run_random_jobs(180);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_preemptive(1'b1);
    run_random_jobs(180);
    set_preemptive(1'b0);
    run_random_jobs(180);
    test_long_burst();

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/lrt_pkg.sv
hdl/longest_remaining_time_scheduler.sv
tb/longest_remaining_time_scheduler_test.sv
